/* sv/tcpq_pkg.sv */
`timescale 1ns / 1ps

package tcpq_pkg;

	// queue geometry
	localparam int DEPTH_PER_CLASS = 16;
	localparam int ID_CHARS        = 5;
	localparam int NUM_CLASSES     = 3;
	localparam int STORE_DEPTH     = NUM_CLASSES * DEPTH_PER_CLASS;

	// field widths
	localparam int ID_W     = 40;
	localparam int AGE_W    = 8;
	localparam int HANDLE_W = 16;
	localparam int CLS_W    = 2;
	localparam int STAT_W   = 3;
	localparam int SLOT_W   = $clog2(DEPTH_PER_CLASS);
	localparam int OCC_W    = $clog2(DEPTH_PER_CLASS + 1);
	localparam int ADDR_W   = $clog2(STORE_DEPTH);
	localparam int ENTRY_W  = ID_W + AGE_W + HANDLE_W;

	// only the characters in use are kept
	localparam int KEEP_BITS = (8 * ID_CHARS > ID_W) ? ID_W : 8 * ID_CHARS;
	localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - KEEP_BITS);

	// opcodes
	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	// class codes
	localparam logic [CLS_W-1:0] CLS_HIGH = 2'd0;
	localparam logic [CLS_W-1:0] CLS_MID  = 2'd1;
	localparam logic [CLS_W-1:0] CLS_LOW  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd1;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd2;
	localparam logic [STAT_W-1:0] STAT_DEQUEUED  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd4;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [AGE_W-1:0]    age;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [ADDR_W-1:0] addr;
		entry_t            wdata;
	} mem_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]   status;
		logic [CLS_W-1:0]    cls;
		logic [ID_W-1:0]     id;
		logic [AGE_W-1:0]    age;
		logic [HANDLE_W-1:0] handle;
	} result_t;

	// store address of a slot within a class region
	function automatic logic [ADDR_W-1:0] entry_addr(input logic [CLS_W-1:0] cls,
			input logic [SLOT_W-1:0] slot);
		logic [ADDR_W-1:0] base;
		unique case (cls)
			CLS_HIGH: base = '0;
			CLS_MID:  base = ADDR_W'(DEPTH_PER_CLASS);
			default:  base = ADDR_W'(2 * DEPTH_PER_CLASS);
		endcase
		return base + ADDR_W'(slot);
	endfunction

	// slot advance with wrap at the class depth
	function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
		return (slot == SLOT_W'(DEPTH_PER_CLASS - 1)) ? '0 : slot + 1'b1;
	endfunction

endpackage

/* sv/tcpq_ram.sv */
`timescale 1ns / 1ps

module tcpq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 48
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read, data held between reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

/* sv/tcpq_ctrl.sv */
`timescale 1ns / 1ps

module tcpq_ctrl import tcpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [CLS_W-1:0]    priority_class,
	input  logic [ID_W-1:0]     patient_id,
	input  logic [AGE_W-1:0]    age,
	input  logic [HANDLE_W-1:0] record_handle,
	output mem_req_t            mem_req,
	input  entry_t              mem_rdata,
	input  logic                res_free,
	output logic                res_valid,
	output result_t             res
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_DEQ,
		S_DEQ_WAIT
	} state_t;

	state_t              state_q;
	logic [CLS_W-1:0]    cls_q;
	logic [ID_W-1:0]     id_q;
	logic [AGE_W-1:0]    age_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [CLS_W-1:0]    scan_cls_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [OCC_W-1:0]    cnt_q;
	logic                dup_q;
	logic                rd_vld_s1;
	logic [CLS_W-1:0]    deq_cls_q;
	logic [SLOT_W-1:0]   rp_q  [NUM_CLASSES];
	logic [SLOT_W-1:0]   wp_q  [NUM_CLASSES];
	logic [OCC_W-1:0]    occ_q [NUM_CLASSES];

	logic             accept;
	logic             scan_more;
	logic             any_occ;
	logic [CLS_W-1:0] head_cls;
	logic             cls_full;
	logic             ins_ok;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	// scan walks occupied slots of one class per pass
	assign scan_more = (cnt_q < occ_q[scan_cls_q]);

	// strict priority head selection
	always_comb begin
		any_occ  = 1'b1;
		head_cls = CLS_HIGH;
		priority if (occ_q[0] != '0) begin
			head_cls = CLS_HIGH;
		end else if (occ_q[1] != '0) begin
			head_cls = CLS_MID;
		end else if (occ_q[2] != '0) begin
			head_cls = CLS_LOW;
		end else begin
			any_occ = 1'b0;
		end
	end

	// full check, unused class code counts as full
	always_comb begin
		unique case (cls_q)
			CLS_HIGH: cls_full = (occ_q[0] == OCC_W'(DEPTH_PER_CLASS));
			CLS_MID:  cls_full = (occ_q[1] == OCC_W'(DEPTH_PER_CLASS));
			CLS_LOW:  cls_full = (occ_q[2] == OCC_W'(DEPTH_PER_CLASS));
			default:  cls_full = 1'b1;
		endcase
	end

	assign ins_ok = !dup_q && !cls_full;

	// memory access and result generation
	always_comb begin
		mem_req   = '0;
		res_valid = 1'b0;
		res       = '0;
		unique case (state_q)
			S_SCAN: begin
				if (scan_more) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = entry_addr(scan_cls_q, slot_q);
				end
			end
			S_DECIDE: begin
				res_valid = res_free;
				if (dup_q) begin
					res.status = STAT_DUPLICATE;
				end else if (cls_full) begin
					res.status = STAT_FULL;
				end else begin
					res.status = STAT_INSERTED;
					mem_req.wr_en  = res_free;
					mem_req.addr   = entry_addr(cls_q, wp_q[cls_q]);
					mem_req.wdata  = '{id: id_q, age: age_q, handle: handle_q};
				end
			end
			S_DEQ: begin
				if (any_occ) begin
					mem_req.rd_en = 1'b1;
					mem_req.addr  = entry_addr(head_cls, rp_q[head_cls]);
				end else begin
					res_valid  = res_free;
					res.status = STAT_EMPTY;
				end
			end
			S_DEQ_WAIT: begin
				res_valid  = res_free;
				res.status = STAT_DEQUEUED;
				res.cls    = deq_cls_q;
				res.id     = mem_rdata.id;
				res.age    = mem_rdata.age;
				res.handle = mem_rdata.handle;
			end
			default: begin
			end
		endcase
	end

	// sequencer, pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cls_q      <= CLS_HIGH;
			id_q       <= '0;
			age_q      <= '0;
			handle_q   <= '0;
			scan_cls_q <= CLS_HIGH;
			slot_q     <= '0;
			cnt_q      <= '0;
			dup_q      <= 1'b0;
			rd_vld_s1  <= 1'b0;
			deq_cls_q  <= CLS_HIGH;
			for (int i = 0; i < NUM_CLASSES; i++) begin
				rp_q[i]  <= '0;
				wp_q[i]  <= '0;
				occ_q[i] <= '0;
			end
		end else begin
			// compare is made in the cycle after the read
			rd_vld_s1 <= mem_req.rd_en;
			if (rd_vld_s1 && (mem_rdata.id == id_q)) begin
				dup_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cls_q    <= priority_class;
						id_q     <= patient_id & ID_MASK;
						age_q    <= age;
						handle_q <= record_handle;
						if (opcode == OP_INSERT) begin
							scan_cls_q <= CLS_HIGH;
							slot_q     <= rp_q[0];
							cnt_q      <= '0;
							dup_q      <= 1'b0;
							state_q    <= S_SCAN;
						end else begin
							state_q <= S_DEQ;
						end
					end
				end
				S_SCAN: begin
					if (scan_more) begin
						slot_q <= next_slot(slot_q);
						cnt_q  <= cnt_q + 1'b1;
					end else if (scan_cls_q == CLS_LOW) begin
						state_q <= S_DECIDE;
					end else begin
						scan_cls_q <= scan_cls_q + 1'b1;
						slot_q     <= rp_q[scan_cls_q + 1'b1];
						cnt_q      <= '0;
					end
				end
				S_DECIDE: begin
					if (res_free) begin
						if (ins_ok) begin
							wp_q[cls_q]  <= next_slot(wp_q[cls_q]);
							occ_q[cls_q] <= occ_q[cls_q] + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				S_DEQ: begin
					if (any_occ) begin
						deq_cls_q <= head_cls;
						state_q   <= S_DEQ_WAIT;
					end else if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				S_DEQ_WAIT: begin
					if (res_free) begin
						rp_q[deq_cls_q]  <= next_slot(rp_q[deq_cls_q]);
						occ_q[deq_cls_q] <= occ_q[deq_cls_q] - 1'b1;
						state_q          <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* sv/three_class_priority_queue_unit.sv */
// insert: the duplicate scan reads one stored entry per cycle from the single-port entry
// memory, class by class, then the decide state registers the result in the output register
// dequeue: the head entry is read, then its result is registered; when all are empty,
// the empty status is registered without a read. requests: one in progress at a time, next
// request taken once the result is in the output register
// reset: arst_n clears pointers, occupancy and control at once; the entry memory is not cleared
`timescale 1ns / 1ps

module three_class_priority_queue_unit import tcpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [CLS_W-1:0]    priority_class,
	input  logic [ID_W-1:0]     patient_id,
	input  logic [AGE_W-1:0]    age,
	input  logic [HANDLE_W-1:0] record_handle,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [STAT_W-1:0]   status,
	output logic [CLS_W-1:0]    out_class,
	output logic [ID_W-1:0]     out_id,
	output logic [AGE_W-1:0]    out_age,
	output logic [HANDLE_W-1:0] out_handle
);

	mem_req_t             mem_req;
	logic [ENTRY_W-1:0]   ram_rdata;
	entry_t               mem_rdata;
	logic                 res_free;
	logic                 res_valid;
	result_t              res;
	logic                 out_valid_q;
	result_t              res_q;

	assign mem_rdata = entry_t'(ram_rdata);

	// entry store shared by all three classes
	tcpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STORE_DEPTH)
	) u_ram (
		.clk   (clk),
		.wr_en (mem_req.wr_en),
		.rd_en (mem_req.rd_en),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (ram_rdata)
	);

	tcpq_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.priority_class (priority_class),
		.patient_id     (patient_id),
		.age            (age),
		.record_handle  (record_handle),
		.mem_req        (mem_req),
		.mem_rdata      (mem_rdata),
		.res_free       (res_free),
		.res_valid      (res_valid),
		.res            (res)
	);

	// output register accepts a new result when empty or being taken
	assign res_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = res_q.status;
	assign out_class  = res_q.cls;
	assign out_id     = res_q.id;
	assign out_age    = res_q.age;
	assign out_handle = res_q.handle;

	// checks
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("entry memory read and write in the same cycle");

	a_result_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> in_stall)
		else $error("result produced with no request in progress");

	a_non_dequeue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.status != STAT_DEQUEUED)) |->
		((res_q.id == '0) && (res_q.age == '0) && (res_q.handle == '0)))
		else $error("non-dequeue result carries entry data");

	a_result_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!out_valid_q || !out_stall))
		else $error("result overwrote a pending output");

endmodule
